@@ rtl/core/rpbt_pkg.sv @@
// rpbt_pkg: shared types, codes and helpers for the ready-priority bitmap tracker
// used by the controller, the datapath and the port checker; no dependencies

package rpbt_pkg;

  // item action codes
  localparam logic ACTION_ADD = 1'b0;

  // result error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_EMPTY    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // cached highest priority when nothing is ready
  localparam logic [7:0] PRIO_NONE = 8'hFF;

  // priorities per bitmap group
  localparam int GROUP_SIZE = 8;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic apply;
    logic find_group;
    logic find_bit;
  } rpbt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_search;
  } rpbt_status_t;

  // index of the lowest set bit of a byte, 0 for an empty byte
  function automatic logic [2:0] low_bit8(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ rtl/core/rpbt_ifs.sv @@
// rpbt_ifs: valid/ready channel interfaces for the input and result words
// no dependencies

// input word: add or remove one task at a priority
interface rpbt_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] task_priority;
  logic       already_ready;

  modport source (output valid, output action, output task_priority,
                  output already_ready, input ready);
  modport sink (input valid, input action, input task_priority,
                input already_ready, output ready);
  modport monitor (input valid, input ready, input action, input task_priority,
                   input already_ready);
endinterface

// result word: highest ready priority and status
interface rpbt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] highest_ready;
  logic       any_ready;
  logic [1:0] error_code;

  modport source (output valid, output highest_ready, output any_ready,
                  output error_code, input ready);
  modport sink (input valid, input highest_ready, input any_ready,
                input error_code, output ready);
  modport monitor (input valid, input ready, input highest_ready, input any_ready,
                   input error_code);
endinterface

@@ rtl/core/rpbt_ctrl.sv @@
// rpbt_ctrl: sequencing state machine of the ready-priority bitmap tracker
// depends on rpbt_pkg for the command and status structs

module rpbt_ctrl
  import rpbt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  rpbt_status_t status,
  output rpbt_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_FIND_GRP,
    ST_FIND_BIT,
    ST_RESP
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= ST_UPDATE;
            in_ready_r <= 1'b0;
          end
        end
        ST_UPDATE: begin
          if (status.need_search) begin
            state_r <= ST_FIND_GRP;
          end else begin
            state_r     <= ST_RESP;
            out_valid_r <= 1'b1;
          end
        end
        ST_FIND_GRP: begin
          state_r <= ST_FIND_BIT;
        end
        ST_FIND_BIT: begin
          state_r     <= ST_RESP;
          out_valid_r <= 1'b1;
        end
        ST_RESP: begin
          if (out_ready) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.load_item  = (state_r == ST_IDLE) && in_valid && in_ready_r;
    cmd.apply      = (state_r == ST_UPDATE);
    cmd.find_group = (state_r == ST_FIND_GRP);
    cmd.find_bit   = (state_r == ST_FIND_BIT);
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/rpbt_dp.sv @@
// rpbt_dp: count memory, ready bitmap, group word and highest-priority cache
// depends on rpbt_pkg for codes, command/status structs and low_bit8

module rpbt_dp
  import rpbt_pkg::*;
#(
  parameter int NUM_PRIORITIES         = 256,
  parameter int MAX_TASKS_PER_PRIORITY = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  input  rpbt_cmd_t    cmd,
  output rpbt_status_t status,
  input  logic         in_action,
  input  logic [7:0]   in_task_priority,
  input  logic         in_already_ready,
  output logic [7:0]   out_highest_ready,
  output logic         out_any_ready,
  output logic [1:0]   out_error_code
);

  localparam int PRIO_W     = $clog2(NUM_PRIORITIES);
  localparam int NUM_GROUPS = (NUM_PRIORITIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int MAP_W      = NUM_GROUPS * GROUP_SIZE;
  localparam int CNT_W      = $clog2(MAX_TASKS_PER_PRIORITY + 1);

  // per-priority task counts; an entry is meaningful only while its bitmap bit is set
  logic [CNT_W-1:0] count_mem [NUM_PRIORITIES];

  // latched word and read data
  logic             action_r;
  logic [7:0]       prio_r;
  logic             ready_flag_r;
  logic [CNT_W-1:0] rd_data_r;
  logic [1:0]       err_r;
  logic [1:0]       err_nxt;
  logic [GRP_W-1:0] grp_sel_r;
  logic [GRP_W-1:0] grp_sel_nxt;

  // ready state
  logic [MAP_W-1:0]      bitmap_r;
  logic [MAP_W-1:0]      bitmap_nxt;
  logic [NUM_GROUPS-1:0] group_word_r;
  logic [NUM_GROUPS-1:0] group_word_nxt;
  logic [7:0]            cached_r;
  logic [7:0]            cached_nxt;

  // update helpers
  logic                  in_range;
  logic [PRIO_W-1:0]     pidx;
  logic [GRP_W-1:0]      grp;
  logic                  bit_set;
  logic [CNT_W-1:0]      cnt_cur;
  logic                  cnt_we;
  logic [CNT_W-1:0]      cnt_wdata;
  logic [MAP_W-1:0]      bitmap_clr;
  logic [NUM_GROUPS-1:0] group_clr;
  logic [7:0]            byte_after;
  logic [GRP_W-1:0]      first_grp;
  logic [7:0]            sel_byte;

  assign in_range   = ({1'b0, prio_r} < 9'(NUM_PRIORITIES));
  assign pidx       = prio_r[PRIO_W-1:0];
  assign grp        = GRP_W'(prio_r >> 3);
  assign bit_set    = in_range && bitmap_r[pidx];
  assign cnt_cur    = bit_set ? rd_data_r : '0;
  assign bitmap_clr = bitmap_r & ~(MAP_W'(1) << pidx);
  assign group_clr  = group_word_r & ~(NUM_GROUPS'(1) << grp);
  assign byte_after = bitmap_clr[{grp, 3'b000} +: GROUP_SIZE];
  assign sel_byte   = bitmap_r[{grp_sel_r, 3'b000} +: GROUP_SIZE];

  // lowest non-empty group
  always_comb begin
    first_grp = '0;
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      if (group_word_r[i]) begin
        first_grp = GRP_W'(i);
      end
    end
  end

  // next-state logic for the update and the two search steps
  always_comb begin
    bitmap_nxt         = bitmap_r;
    group_word_nxt     = group_word_r;
    cached_nxt         = cached_r;
    err_nxt            = err_r;
    grp_sel_nxt        = grp_sel_r;
    cnt_we             = 1'b0;
    cnt_wdata          = cnt_cur;
    status             = '0;
    if (cmd.apply) begin
      err_nxt = ERR_OK;
      if (in_range) begin
        if (action_r == ACTION_ADD) begin
          if (!ready_flag_r) begin
            if (cnt_cur >= CNT_W'(MAX_TASKS_PER_PRIORITY)) begin
              err_nxt = ERR_OVERFLOW;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_cur + CNT_W'(1);
              if (!bit_set) begin
                bitmap_nxt     = bitmap_r | (MAP_W'(1) << pidx);
                group_word_nxt = group_word_r | (NUM_GROUPS'(1) << grp);
                if (prio_r < cached_r) begin
                  cached_nxt = prio_r;
                end
              end
            end
          end
        end else begin
          if (!bit_set) begin
            err_nxt = ERR_EMPTY;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_cur - CNT_W'(1);
            // last task leaves the priority
            if (cnt_cur == CNT_W'(1)) begin
              bitmap_nxt = bitmap_clr;
              if (byte_after == 8'd0) begin
                group_word_nxt = group_clr;
              end
              if (cached_r == prio_r) begin
                if (((byte_after == 8'd0) ? group_clr : group_word_r) == '0) begin
                  cached_nxt = PRIO_NONE;
                end else begin
                  status.need_search = 1'b1;
                end
              end
            end
          end
        end
      end
    end
    if (cmd.find_group) begin
      grp_sel_nxt = first_grp;
    end
    if (cmd.find_bit) begin
      cached_nxt = 8'({grp_sel_r, low_bit8(sel_byte)});
    end
  end

  // ready state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r     <= '0;
      group_word_r <= '0;
      cached_r     <= PRIO_NONE;
    end else begin
      bitmap_r     <= bitmap_nxt;
      group_word_r <= group_word_nxt;
      cached_r     <= cached_nxt;
    end
  end

  // word latch, count memory and search registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r     <= in_action;
      prio_r       <= in_task_priority;
      ready_flag_r <= in_already_ready;
      rd_data_r    <= count_mem[in_task_priority[PRIO_W-1:0]];
    end
    if (cnt_we) begin
      count_mem[pidx] <= cnt_wdata;
    end
    err_r     <= err_nxt;
    grp_sel_r <= grp_sel_nxt;
  end

  // result word
  assign out_any_ready     = |group_word_r;
  assign out_highest_ready = out_any_ready ? cached_r : 8'd0;
  assign out_error_code    = err_r;

endmodule

@@ rtl/core/ready_priority_bitmap_tracker_core.sv @@
// ready_priority_bitmap_tracker_core: top level of the ready-priority bitmap tracker
// depends on rpbt_pkg, rpbt_ifs, rpbt_ctrl and rpbt_dp
//
// Usage:
//   in_ch carries one word per scheduler event: add (action 0) or remove
//   (action 1) one task at task_priority; already_ready set on an add
//   leaves everything unchanged.
//   out_ch returns exactly one word per input word: highest_ready (lowest
//   numbered priority with ready tasks, 0 when none), any_ready and
//   error_code (remove from an empty priority, or count overflow).
//   The word is latched and its count read into a register at the input
//   handshake, then applied in the update state before the result shows;
//   when the highest priority empties, a two-step search (group word, then
//   the group's bitmap byte) finds the new one first. One word at a time:
//   in_ch.ready rises the cycle after the result is taken.
//   Reset (synchronous, rst_n low) clears the bitmap and the group word and
//   sets the cache to 255; counts need no clearing since a clear bitmap bit
//   means a zero count. The block is ready right after reset.
//   A stalled receiver holds the result word steady and keeps in_ch.ready low.

module ready_priority_bitmap_tracker_core
  import rpbt_pkg::*;
#(
  parameter int NUM_PRIORITIES         = 256,
  parameter int MAX_TASKS_PER_PRIORITY = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  rpbt_in_if.sink       in_ch,
  rpbt_out_if.source    out_ch
);

  rpbt_cmd_t    cmd;
  rpbt_status_t status;

  // sequencing
  rpbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // state and search logic
  rpbt_dp #(
    .NUM_PRIORITIES         (NUM_PRIORITIES),
    .MAX_TASKS_PER_PRIORITY (MAX_TASKS_PER_PRIORITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_action         (in_ch.action),
    .in_task_priority  (in_ch.task_priority),
    .in_already_ready  (in_ch.already_ready),
    .out_highest_ready (out_ch.highest_ready),
    .out_any_ready     (out_ch.any_ready),
    .out_error_code    (out_ch.error_code)
  );

endmodule

@@ rtl/core/rpbt_checker.sv @@
// rpbt_checker: port-level assertions for the ready-priority bitmap tracker
// depends on rpbt_pkg; bound to ready_priority_bitmap_tracker_core

module rpbt_checker
  import rpbt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_highest_ready,
  input logic       out_any_ready,
  input logic [1:0] out_error_code
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_highest_ready)
      && $stable(out_any_ready) && $stable(out_error_code))
    else $error("result word changed while stalled");

  // one word in flight: no new input while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  // an accepted word produces no result in the next cycle
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result appeared too early");

  // empty ready set reports priority zero
  a_empty_prio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_ready |-> out_highest_ready == 8'd0)
    else $error("nonzero priority with nothing ready");

  // error code stays within its defined set
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code == ERR_OK || out_error_code == ERR_EMPTY
      || out_error_code == ERR_OVERFLOW))
    else $error("undefined error code");

endmodule

bind ready_priority_bitmap_tracker_core rpbt_checker u_rpbt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_highest_ready (out_ch.highest_ready),
  .out_any_ready     (out_ch.any_ready),
  .out_error_code    (out_ch.error_code)
);
